### hdl/psrdf_pkg.sv
// Package: shared types and constants of the replay/dedup filter.
`default_nettype none
package psrdf_pkg;
    localparam logic [63:0] MIX_CONST = 64'h9e3779b97f4a7c15;
    localparam int unsigned EVENT_WORDS = 12;
    localparam logic [15:0] MIN_RELAY_RESET = 16'd45;
    localparam logic [15:0] SIG_LIFE_RESET = 16'd750;
    localparam logic [0:0] REG_MIN_RELAY = 1'b0;
    localparam logic [0:0] REG_SIG_LIFE = 1'b1;

    typedef enum logic [2:0] {
        V_RELAY = 3'd0,
        V_INVALID = 3'd1,
        V_STALE = 3'd2,
        V_RATE = 3'd3,
        V_DUP = 3'd4
    } verdict_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SCAN,
        ST_WRITE
    } state_t;

    function automatic logic [63:0] fold(input logic [63:0] h, input logic [63:0] w);
        fold = h ^ (w + MIX_CONST + (h << 6) + (h >> 2));
    endfunction

    function automatic logic seq_newer(input logic [31:0] cand, input logic [31:0] cur);
        logic [31:0] d;
        d = cand - cur;
        seq_newer = (d != 32'd0) && !d[31];
    endfunction
endpackage
`default_nettype wire

### hdl/psrdf_if.sv
// Interfaces: input and result channels.
`default_nettype none
interface psrdf_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [3:0]  player_slot;
    logic [31:0] sequence_req;
    logic [47:0] now_tick;
    logic [63:0] word_value;
    logic        word_last;
    modport source (output valid, command, player_slot, sequence_req, now_tick,
                     word_value, word_last, input ready);
    modport sink (input valid, command, player_slot, sequence_req, now_tick,
                  word_value, word_last, output ready);
endinterface

interface psrdf_out_if;
    logic       valid;
    logic       ready;
    logic       relay;
    logic [2:0] verdict;
    logic [3:0] slot_out;
    modport source (output valid, relay, verdict, slot_out, input ready);
    modport sink (input valid, relay, verdict, slot_out, output ready);
endinterface
`default_nettype wire

### hdl/psrdf_hash.sv
// Word folding hash, position counter and context flags.
`default_nettype none
module psrdf_hash
    import psrdf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        step,
    input  wire logic        clear,
    input  wire logic [63:0] word,
    output logic [63:0]      sig,
    output logic             pos_ok,
    output logic             ctx_ok
);
    logic [63:0] hash_reg;
    logic [3:0]  pos_reg;
    logic [3:0]  ctx_reg;
    logic [3:0]  ctx_next;

    assign sig = fold(hash_reg, word);

    always_comb
    begin
        ctx_next = ctx_reg;
        if (word != 64'd0) begin
            case (pos_reg)
                4'd0: ctx_next[0] = 1'b1;
                4'd1: ctx_next[1] = 1'b1;
                4'd10: ctx_next[2] = 1'b1;
                4'd11: ctx_next[3] = 1'b1;
                default: ctx_next = ctx_reg;
            endcase
        end
    end

    assign pos_ok = (pos_reg == 4'(EVENT_WORDS - 1));
    assign ctx_ok = (ctx_next[3:2] != 2'd0) && (ctx_next[1:0] != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            hash_reg <= '0;
            pos_reg <= '0;
            ctx_reg <= '0;
        end else if (clear) begin
            hash_reg <= '0;
            pos_reg <= '0;
            ctx_reg <= '0;
        end else if (step) begin
            hash_reg <= sig;
            ctx_reg <= ctx_next;
            if (pos_reg != 4'd15)
                pos_reg <= pos_reg + 4'd1;
        end
    end
endmodule
`default_nettype wire

### hdl/psrdf_ring.sv
// Signature ring memory with per-entry valid bits.
`default_nettype none
module psrdf_ring #(
    parameter int SLOTS = 16,
    parameter int RING_DEPTH = 8,
    parameter int SW = 4,
    parameter int RW = 3
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic [SW-1:0]  rd_slot,
    input  wire logic [RW-1:0]  rd_idx,
    output logic [111:0]        rd_data,
    output logic                rd_valid,
    input  wire logic           wr_en,
    input  wire logic [SW-1:0]  wr_slot,
    input  wire logic [RW-1:0]  wr_idx,
    input  wire logic [111:0]   wr_data,
    input  wire logic           clr_en,
    input  wire logic [SW-1:0]  clr_slot
);
    localparam int N = SLOTS * RING_DEPTH;
    localparam int AW = SW + RW;
    logic [111:0] mem [N];
    logic [N-1:0] valid_reg;
    logic [AW-1:0] wa, ra;

    assign wa = AW'(wr_slot) * AW'(RING_DEPTH) + AW'(wr_idx);
    assign ra = AW'(rd_slot) * AW'(RING_DEPTH) + AW'(rd_idx);

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wa] <= wr_data;
        rd_data <= mem[ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= '0;
            rd_valid <= 1'b0;
        end else begin
            rd_valid <= valid_reg[ra];
            for (int k = 0; k < N; k++) begin
                if (clr_en && (k / RING_DEPTH) == int'(clr_slot))
                    valid_reg[k] <= 1'b0;
            end
            if (wr_en)
                valid_reg[wa] <= 1'b1;
        end
    end
endmodule
`default_nettype wire

### hdl/per_source_replay_dedup_filter.sv
// Top level: per-source replay and duplicate admission filter.
// An event is twelve words on the input channel. An invalid last word places
// its verdict item in the output register on the next cycle and the block
// stays idle. A valid last word reads the slot state memory. It then scans the
// slot's signature ring one entry per cycle, up to RING_DEPTH entries and ending
// early on a live match; the single ring read port sets this. It then writes
// state back and places the verdict item in the output register. A valid event
// therefore holds the input off through the read, scan and write states after
// its last word. The input is also held off while a verdict item waits on the
// output. Leave commands clear a slot at once; ring valid bits are flip-flops
// cleared per slot at once. No clearing pass after reset.
`default_nettype none
module per_source_replay_dedup_filter
    import psrdf_pkg::*;
#(
    parameter int SLOTS = 16,
    parameter int RING_DEPTH = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    psrdf_in_if.sink         in_ch,
    psrdf_out_if.source      out_ch,
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int RW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CW = $clog2(RING_DEPTH + 1);

    state_t state_reg, state_next;
    logic [15:0] min_int_reg, life_reg;
    logic out_valid_reg;
    logic out_set;
    verdict_t verdict_reg;
    logic [3:0] slot_out_reg;

    // captured last-word event
    logic [SW-1:0] slot_reg;
    logic [31:0] seq_reg;
    logic [47:0] now_reg;
    logic [63:0] sig_reg;
    logic bad_reg;
    logic [CW-1:0] scan_reg;
    logic dup_reg;

    // slot state memory: seq(32) seen(1) time(48) next(RW)
    localparam int STW = 32 + 1 + 48 + RW;
    logic [STW-1:0] st_mem [SLOTS];
    logic [SLOTS-1:0] st_live_reg;
    logic [STW-1:0] st_rd;
    logic st_rd_live;
    logic st_we;
    logic [STW-1:0] st_wd;

    logic acc, is_leave, leave_ok, slot_in_range;
    logic [63:0] sig;
    logic pos_ok, ctx_ok;

    assign acc = in_ch.valid && in_ch.ready;
    assign is_leave = in_ch.command;
    assign slot_in_range = (32'(in_ch.player_slot) < 32'(SLOTS));
    assign leave_ok = acc && is_leave && slot_in_range;
    assign in_ch.ready = (state_reg == ST_IDLE) && !(out_valid_reg && !out_ch.ready);

    psrdf_hash u_hash (
        .clk(clk), .rst_n(rst_n),
        .step(acc && !is_leave && !in_ch.word_last),
        .clear(acc && !is_leave && in_ch.word_last),
        .word(in_ch.word_value), .sig(sig), .pos_ok(pos_ok), .ctx_ok(ctx_ok)
    );

    function automatic logic bad_next_c();
        bad_next_c = !slot_in_range || (in_ch.sequence_req == 32'd0) || !ctx_ok || !pos_ok;
    endfunction

    // slot state fields (not-live entries read as reset)
    logic [31:0] s_seq;
    logic s_seen;
    logic [47:0] s_time;
    logic [RW-1:0] s_next;
    assign s_seq  = st_rd_live ? st_rd[STW-1 -: 32] : 32'd0;
    assign s_seen = st_rd_live ? st_rd[STW-33] : 1'b0;
    assign s_time = st_rd_live ? st_rd[RW +: 48] : 48'd0;
    assign s_next = st_rd_live ? st_rd[RW-1:0] : '0;

    logic [111:0] ring_rd;
    logic ring_rd_valid;
    logic ring_we;

    psrdf_ring #(.SLOTS(SLOTS), .RING_DEPTH(RING_DEPTH), .SW(SW), .RW(RW)) u_ring (
        .clk(clk), .rst_n(rst_n),
        .rd_slot(slot_reg), .rd_idx(scan_reg[RW-1:0]),
        .rd_data(ring_rd), .rd_valid(ring_rd_valid),
        .wr_en(ring_we), .wr_slot(slot_reg),
        .wr_idx(s_next), .wr_data({now_reg, sig_reg}),
        .clr_en(leave_ok), .clr_slot(in_ch.player_slot[SW-1:0])
    );

    logic stale, rate;
    logic [47:0] dt;
    assign stale = s_seen && !seq_newer(seq_reg, s_seq);
    assign dt = now_reg - s_time;
    assign rate = (s_time != 48'd0) && (now_reg >= s_time) && (dt < 48'(min_int_reg));

    // ring compare on the registered read
    logic [47:0] r_time;
    logic hit;
    assign r_time = ring_rd[111:64];
    assign hit = ring_rd_valid && (ring_rd[63:0] == sig_reg) && (now_reg >= r_time)
                 && ((now_reg - r_time) < 48'(life_reg));

    logic [RW-1:0] wr_ptr;
    assign wr_ptr = (32'(s_next) == RING_DEPTH - 1) ? '0 : s_next + RW'(1);

    // a verdict item is loaded on an invalid last word or at the end of a scan
    assign out_set = (state_reg == ST_WRITE) ||
                     ((state_reg == ST_IDLE) && acc && !is_leave && in_ch.word_last &&
                      bad_next_c());

    always_comb
    begin
        state_next = state_reg;
        st_we = 1'b0;
        st_wd = {seq_reg, 1'b1, s_time, s_next};
        ring_we = 1'b0;
        case (state_reg)
            ST_IDLE: if (acc && !is_leave && in_ch.word_last && !bad_next_c())
                         state_next = ST_READ;
            ST_READ: state_next = ST_SCAN;
            ST_SCAN: if (hit || scan_reg == CW'(RING_DEPTH)) state_next = ST_WRITE;
            ST_WRITE:
            begin
                state_next = ST_IDLE;
                if (!stale && !rate) begin
                    st_we = 1'b1;
                    if (!dup_reg) begin
                        st_wd = {seq_reg, 1'b1, now_reg, wr_ptr};
                        ring_we = 1'b1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // slot state memory, one read and one write per cycle
    always_ff @(posedge clk)
    begin
        if (st_we)
            st_mem[slot_reg] <= st_wd;
        st_rd <= st_mem[slot_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            min_int_reg <= MIN_RELAY_RESET;
            life_reg <= SIG_LIFE_RESET;
            out_valid_reg <= 1'b0;
            verdict_reg <= V_RELAY;
            slot_out_reg <= '0;
            st_live_reg <= '0;
            st_rd_live <= 1'b0;
            scan_reg <= '0;
            dup_reg <= 1'b0;
            bad_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            st_rd_live <= st_live_reg[slot_reg];
            if (cfg_we) begin
                if (cfg_index == REG_MIN_RELAY) min_int_reg <= cfg_data;
                else life_reg <= cfg_data;
            end
            if (out_set)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ch.ready)
                out_valid_reg <= 1'b0;
            if (leave_ok)
                st_live_reg[in_ch.player_slot[SW-1:0]] <= 1'b0;
            if (st_we)
                st_live_reg[slot_reg] <= 1'b1;
            case (state_reg)
                ST_IDLE:
                begin
                    scan_reg <= '0;
                    dup_reg <= 1'b0;
                    if (acc && !is_leave && in_ch.word_last) begin
                        slot_out_reg <= in_ch.player_slot;
                        bad_reg <= bad_next_c();
                        if (bad_next_c())
                            verdict_reg <= V_INVALID;
                    end
                end
                ST_READ: scan_reg <= scan_reg + CW'(1);
                ST_SCAN:
                begin
                    if (hit) dup_reg <= 1'b1;
                    if (scan_reg != CW'(RING_DEPTH)) scan_reg <= scan_reg + CW'(1);
                end
                ST_WRITE:
                begin
                    verdict_reg <= stale ? V_STALE : rate ? V_RATE :
                                   dup_reg ? V_DUP : V_RELAY;
                end
                default: scan_reg <= '0;
            endcase
        end
    end

    // scan compares the registered read of entry scan_reg-1: ring address leads
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && acc && !is_leave && in_ch.word_last) begin
            slot_reg <= in_ch.player_slot[SW-1:0];
            seq_reg <= in_ch.sequence_req;
            now_reg <= in_ch.now_tick;
            sig_reg <= sig;
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.relay = (verdict_reg == V_RELAY);
    assign out_ch.verdict = verdict_reg;
    assign out_ch.slot_out = slot_out_reg;

    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !in_ch.ready) else $error("accept while busy");
    a_write_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRITE) |=> out_valid_reg) else $error("no result after write");
    a_ring_we: assert property (@(posedge clk) disable iff (!rst_n)
        ring_we |-> st_we) else $error("ring write without state write");
    a_bad_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> !bad_reg) else $error("invalid event processed");
endmodule
`default_nettype wire

### verif/psrdf_test_if.sv
// Testbench-side note: channel interfaces come from hdl/psrdf_if.sv; this file holds test types.
`default_nettype none
package psrdf_test_pkg;
    import psrdf_pkg::*;

    typedef struct packed {
        logic        command;
        logic [3:0]  player_slot;
        logic [31:0] sequence_req;
        logic [47:0] now_tick;
        logic [63:0] word_value;
        logic        word_last;
    } hit_word_t;

    typedef struct packed {
        logic     relay;
        verdict_t verdict;
        logic [3:0] slot_out;
    } verdict_item_t;
endpackage
`default_nettype wire

### verif/per_source_replay_dedup_filter_test.sv
// Testbench: drives hit events and leave commands, predicts every verdict and checks it.
`default_nettype none
module per_source_replay_dedup_filter_test;
    import psrdf_pkg::*;
    import psrdf_test_pkg::*;

    localparam int NSLOT = 16;
    localparam int RDEPTH = 8;
    // settle time after the last verdict before a register write or the end
    localparam int DRAIN_CYCLES = 40;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [0:0]  cfg_index = REG_MIN_RELAY;
    logic [15:0] cfg_data = '0;

    psrdf_in_if  in_ch ();
    psrdf_out_if out_ch ();

    per_source_replay_dedup_filter #(.SLOTS(NSLOT), .RING_DEPTH(RDEPTH)) u_dut (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------- filter state mirror ----------------
    logic [15:0] min_gap;
    logic [15:0] sig_life;
    logic [63:0] mix_acc;
    logic [3:0]  word_pos;
    logic [3:0]  ctx_bits;
    logic [31:0] slot_seq [NSLOT];
    logic        slot_seq_ok [NSLOT];
    logic [47:0] slot_relay_at [NSLOT];
    logic [2:0]  slot_ring_ptr [NSLOT];
    logic [63:0] ring_sig [NSLOT*RDEPTH];
    logic [47:0] ring_at [NSLOT*RDEPTH];
    logic        ring_live [NSLOT*RDEPTH];

    hit_word_t     pending_words [$];
    verdict_item_t expected_verdicts [$];
    int            error_count = 0;
    bit            idle_allowed = 1'b1;

    function automatic logic [63:0] mix_word(logic [63:0] h, logic [63:0] w);
        return h ^ (w + 64'h9e3779b97f4a7c15 + (h << 6) + (h >> 2));
    endfunction

    function automatic bit serial_after(logic [31:0] cand, logic [31:0] cur);
        logic [31:0] d;
        d = cand - cur;
        return (d != 0) && (d[31] == 1'b0);
    endfunction

    task automatic mirror_reset();
        min_gap = MIN_RELAY_RESET;
        sig_life = SIG_LIFE_RESET;
        mix_acc = '0;
        word_pos = '0;
        ctx_bits = '0;
        for (int s = 0; s < NSLOT; s++)
        begin
            slot_seq[s] = '0;
            slot_seq_ok[s] = 1'b0;
            slot_relay_at[s] = '0;
            slot_ring_ptr[s] = '0;
        end
        for (int e = 0; e < NSLOT*RDEPTH; e++)
        begin
            ring_sig[e] = '0;
            ring_at[e] = '0;
            ring_live[e] = 1'b0;
        end
    endtask

    function automatic verdict_t judge_event(int s, logic [31:0] seq, logic [47:0] now,
                                            logic [63:0] sig);
        int e;
        if (seq == 0 || ctx_bits[3:2] == 0 || ctx_bits[1:0] == 0 || word_pos != 4'd11)
            return V_INVALID;
        if (slot_seq_ok[s] && !serial_after(seq, slot_seq[s]))
            return V_STALE;
        if (slot_relay_at[s] != 0 && now >= slot_relay_at[s] &&
            (now - slot_relay_at[s]) < {32'd0, min_gap})
            return V_RATE;
        for (int k = 0; k < RDEPTH; k++)
        begin
            e = s*RDEPTH + k;
            if (ring_live[e] && ring_sig[e] == sig && now >= ring_at[e] &&
                (now - ring_at[e]) < {32'd0, sig_life})
            begin
                slot_seq[s] = seq;
                slot_seq_ok[s] = 1'b1;
                return V_DUP;
            end
        end
        slot_seq[s] = seq;
        slot_seq_ok[s] = 1'b1;
        slot_relay_at[s] = now;
        e = s*RDEPTH + slot_ring_ptr[s];
        ring_sig[e] = sig;
        ring_at[e] = now;
        ring_live[e] = 1'b1;
        slot_ring_ptr[s] = slot_ring_ptr[s] + 3'd1;
        return V_RELAY;
    endfunction

    // Advance the mirror by one accepted item; queue a verdict on a last word.
    task automatic predict_item(hit_word_t it);
        logic [63:0] sig;
        verdict_item_t r;
        if (it.command)
        begin
            // leave: wipe slot, partial event in flight is untouched
            slot_seq[it.player_slot] = '0;
            slot_seq_ok[it.player_slot] = 1'b0;
            slot_relay_at[it.player_slot] = '0;
            slot_ring_ptr[it.player_slot] = '0;
            for (int k = 0; k < RDEPTH; k++)
                ring_live[it.player_slot*RDEPTH + k] = 1'b0;
            return;
        end
        sig = mix_word(mix_acc, it.word_value);
        if (it.word_value != 0)
        begin
            case (word_pos)
                4'd0: ctx_bits[0] = 1'b1;
                4'd1: ctx_bits[1] = 1'b1;
                4'd10: ctx_bits[2] = 1'b1;
                4'd11: ctx_bits[3] = 1'b1;
                default: ;
            endcase
        end
        if (!it.word_last)
        begin
            mix_acc = sig;
            if (word_pos != 4'd15)
                word_pos = word_pos + 4'd1;
            return;
        end
        r.verdict = judge_event(it.player_slot, it.sequence_req, it.now_tick, sig);
        r.relay = (r.verdict == V_RELAY);
        r.slot_out = it.player_slot;
        expected_verdicts.push_back(r);
        mix_acc = '0;
        word_pos = '0;
        ctx_bits = '0;
    endtask

    task automatic report_mismatch(string what);
        $display("MISMATCH @%0t: %s", $time, what);
        error_count++;
    endtask

    // ---------------- driver ----------------
    int send_idle = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.command <= 1'b0;
            in_ch.player_slot <= '0;
            in_ch.sequence_req <= '0;
            in_ch.now_tick <= '0;
            in_ch.word_value <= '0;
            in_ch.word_last <= 1'b0;
            send_idle <= 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
                predict_item(pending_words.pop_front());
            if (!in_ch.valid || in_ch.ready)
            begin
                if (send_idle > 0)
                begin
                    send_idle <= send_idle - 1;
                    in_ch.valid <= 1'b0;
                end
                else if (idle_allowed && $urandom_range(0, 9) == 0)
                begin
                    send_idle <= $urandom_range(0, 14);
                    in_ch.valid <= 1'b0;
                end
                else if (pending_words.size() > 0)
                begin
                    in_ch.valid <= 1'b1;
                    {in_ch.command, in_ch.player_slot, in_ch.sequence_req, in_ch.now_tick,
                     in_ch.word_value, in_ch.word_last} <= pending_words[0];
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // ---------------- monitor ----------------
    int recv_idle = 0;
    verdict_item_t want;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            recv_idle <= 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_verdicts.size() == 0)
                    report_mismatch("verdict item with nothing expected");
                else
                begin
                    want = expected_verdicts.pop_front();
                    if (out_ch.relay !== want.relay)
                        report_mismatch($sformatf("relay %0b want %0b", out_ch.relay,
                                                  want.relay));
                    if (out_ch.verdict !== want.verdict)
                        report_mismatch($sformatf("verdict %0d want %0d", out_ch.verdict,
                                                  want.verdict));
                    if (out_ch.slot_out !== want.slot_out)
                        report_mismatch($sformatf("slot %0d want %0d", out_ch.slot_out,
                                                  want.slot_out));
                end
            end
            if (recv_idle > 0)
            begin
                recv_idle <= recv_idle - 1;
                out_ch.ready <= 1'b0;
            end
            else if (idle_allowed && $urandom_range(0, 9) == 0)
            begin
                recv_idle <= $urandom_range(0, 14);
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // ---------------- stimulus helpers ----------------
    logic [47:0] clock_ms = 48'd1000;

    function automatic hit_word_t make_word(int slot, logic [31:0] seq, logic [47:0] now,
                                            logic [63:0] w, bit last);
        hit_word_t it;
        it.command = 1'b0;
        it.player_slot = slot[3:0];
        it.sequence_req = seq;
        it.now_tick = now;
        it.word_value = w;
        it.word_last = last;
        return it;
    endfunction

    // One event of n words; the event words are given in ev.
    task automatic queue_event(int slot, logic [31:0] seq, logic [47:0] now,
                               logic [63:0] ev [12], int n);
        for (int i = 0; i < n; i++)
            pending_words.push_back(make_word(slot, $urandom, 48'({$urandom, $urandom}),
                                              ev[i % 12], 1'b0));
        pending_words[$].sequence_req = seq;
        pending_words[$].now_tick = now;
        pending_words[$].word_last = 1'b1;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Plausible event content; nonzero ids and player flags set.
    task automatic fill_event(output logic [63:0] ev [12], input int variety);
        for (int i = 0; i < 12; i++)
            ev[i] = (variety == 0) ? 64'(i + 1) : rand64();
        ev[9] = 64'($urandom_range(0, 1));
        ev[10] = 64'($urandom_range(0, 1));
        ev[11] = 64'($urandom_range(0, 1));
        if (ev[10] == 0 && ev[11] == 0)
            ev[10] = 64'd1;
    endtask

    task automatic queue_leave(int slot);
        hit_word_t it;
        it = make_word(slot, $urandom, 48'(rand64()), rand64(), 1'($urandom_range(0, 1)));
        it.command = 1'b1;
        pending_words.push_back(it);
    endtask

    task automatic drain();
        while (pending_words.size() > 0 || expected_verdicts.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_MIN_RELAY)
            min_gap = val;
        else
            sig_life = val;
    endtask

    initial
    begin
        logic [63:0] ev [12];
        logic [63:0] held [12];
        logic [31:0] seq_of [NSLOT];
        int slot, pick, n;

        mirror_reset();
        for (int s = 0; s < NSLOT; s++)
            seq_of[s] = 32'd1;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed: reset settings ----
        fill_event(ev, 0);
        queue_event(0, 1, 48'd1000, ev, 12);           // relayed
        queue_event(0, 1, 48'd2000, ev, 12);           // stale: same sequence
        queue_event(0, 2, 48'd1010, ev, 12);           // rate limited
        queue_event(0, 3, 48'd1100, ev, 12);           // duplicate signature
        queue_event(0, 4, 48'd1900, ev, 12);           // signature expired: relayed
        queue_event(0, 0, 48'd3000, ev, 12);           // zero sequence: invalid
        queue_event(1, 5, 48'd3000, ev, 11);           // short event: invalid
        queue_event(1, 6, 48'd3000, ev, 14);           // long event: invalid
        held = ev;
        held[10] = 0;
        held[11] = 0;
        queue_event(2, 7, 48'd3000, held, 12);         // no player flag: invalid
        held = ev;
        held[0] = 0;
        held[1] = 0;
        queue_event(2, 8, 48'd3000, held, 12);         // no ids: invalid
        queue_event(3, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, ev, 12);
        queue_event(3, 32'h7FFF_FFFF, 48'hFFFF_FFFF_FFFF, ev, 12); // half-range: stale
        queue_event(3, 32'h0000_0005, 48'd500, ev, 12);  // clock behind stored time
        queue_leave(3);
        queue_event(3, 32'h0000_0002, 48'd600, ev, 12);  // slot fresh after leave
        // leave inside a partial event does not disturb it
        for (int i = 0; i < 6; i++)
            pending_words.push_back(make_word(15, 1, 1, ev[i], 1'b0));
        queue_leave(15);
        for (int i = 6; i < 12; i++)
            pending_words.push_back(make_word(15, 9, 48'd4000, ev[i], i == 11));
        drain();

        // ---- register extremes ----
        write_reg(REG_MIN_RELAY, 16'd0);
        write_reg(REG_SIG_LIFE, 16'hFFFF);
        fill_event(ev, 1);
        queue_event(4, 1, 48'd10, ev, 12);
        queue_event(4, 2, 48'd10, ev, 12);             // same tick, duplicate
        queue_event(4, 3, 48'd10 + 48'hFFFE, ev, 12);
        drain();
        write_reg(REG_MIN_RELAY, 16'hFFFF);
        write_reg(REG_SIG_LIFE, 16'd0);
        queue_event(5, 1, 48'd20, ev, 12);
        queue_event(5, 2, 48'd20 + 48'hFFFE, ev, 12);  // rate limited
        queue_event(6, 1, 48'd20, ev, 12);             // lifetime zero: never duplicate
        drain();

        // ---- random phases ----
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin write_reg(REG_MIN_RELAY, 16'd45); write_reg(REG_SIG_LIFE, 16'd750); end
                1: begin write_reg(REG_MIN_RELAY, 16'($urandom_range(0, 60)));
                         write_reg(REG_SIG_LIFE, 16'($urandom_range(0, 3000))); end
                2: begin write_reg(REG_MIN_RELAY, 16'($urandom));
                         write_reg(REG_SIG_LIFE, 16'($urandom)); end
                default: begin write_reg(REG_MIN_RELAY, 16'd5);
                               write_reg(REG_SIG_LIFE, 16'd400); idle_allowed = 1'b0; end
            endcase
            for (int e = 0; e < 21; e++)
            begin
                slot = $urandom_range(0, NSLOT - 1);
                pick = $urandom_range(0, 19);
                clock_ms = clock_ms + $urandom_range(0, 80);
                if (pick < 6)
                    ev = held;                          // replay of an earlier event
                else
                    fill_event(ev, 1);
                if (pick == 0)
                    queue_leave(slot);
                else if (pick == 1)
                begin
                    // noise: random words, random lengths, random fields
                    n = $urandom_range(1, 16);
                    for (int i = 0; i < n; i++)
                        pending_words.push_back(make_word($urandom, $urandom, 48'(rand64()),
                                                          rand64(), i == n - 1));
                    continue;
                end
                if (pick == 2)
                    seq_of[slot] = seq_of[slot] - $urandom_range(0, 3);
                else if (pick == 3)
                    seq_of[slot] = $urandom;
                else
                    seq_of[slot] = seq_of[slot] + $urandom_range(1, 3);
                n = (pick == 4) ? $urandom_range(1, 15) : 12;
                queue_event(slot, seq_of[slot],
                            (pick == 5) ? clock_ms - $urandom_range(0, 200) : clock_ms, ev, n);
                held = ev;
            end
            drain();
        end

        if (error_count == 0)
            $display("** per_source_replay_dedup_filter: PASSED **");
        else
            $display("** per_source_replay_dedup_filter: FAILED **");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("** per_source_replay_dedup_filter: FAILED **");
        $finish;
    end
endmodule
